// ----- src/vaxt_pkg.sv -----
// Shared constants, types and helpers of the vector ALU with matrix transform.
`timescale 1ns / 1ps

package vaxt_pkg;

   // Number format and port widths
   localparam int FRAC_BITS  = 16;
   localparam int WORD_WIDTH = 32;
   localparam int IO_W       = 32;
   localparam int FRAC_W     = 17;
   localparam int OP_W       = 3;

   // Datapath sizes
   localparam int NUM_LANES = 16;
   localparam int NUM_GRP   = 4;
   localparam int LANE_GRP  = NUM_LANES / NUM_GRP;
   localparam int OPND_W    = IO_W + 1;
   localparam int PRODF_W   = 2 * OPND_W;
   localparam int PROD_W    = PRODF_W - FRAC_BITS;
   localparam int SUM_W     = PROD_W + 3;

   // Configuration port
   localparam int NUM_REGS = 8;
   localparam int CSR_AW   = 6;
   localparam int CSR_DW   = 64;
   localparam int IDX_W    = 3;

   localparam logic [NUM_REGS-1:0][CSR_DW-1:0] REG_RESET = {
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000
   };

   // Saturation bounds of the result word
   localparam logic signed [SUM_W-1:0] SAT_HI =
      (SUM_W'(1) <<< (WORD_WIDTH - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

   // Constant one, clipped to the word range when it does not fit
   localparam logic [63:0] ONE_RAW  = 64'd1 << FRAC_BITS;
   localparam logic [63:0] WMAX_RAW = (64'd1 << (WORD_WIDTH - 1)) - 64'd1;
   localparam logic [IO_W-1:0] ONE_OUT =
      IO_W'((ONE_RAW > WMAX_RAW) ? WMAX_RAW : ONE_RAW);

   typedef enum logic [OP_W-1:0] {
      OP_ADD   = 3'd0,
      OP_SUB   = 3'd1,
      OP_DOT   = 3'd2,
      OP_CROSS = 3'd3,
      OP_LERP  = 3'd4,
      OP_XFORM = 3'd5
   } opcode_type;

   typedef struct packed {
      logic valid;
      logic enable;
   } stage_ctl_type;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic [3:0][IO_W-1:0]      a;
      logic [2:0][IO_W-1:0]      b;
      logic [FRAC_W-1:0]         frac;
   } item_type;

   // Matrix elements indexed [row][col]
   typedef logic [3:0][3:0][IO_W-1:0] matrix_type;

   typedef struct packed {
      logic [OP_W-1:0]                   op;
      logic [NUM_LANES-1:0][OPND_W-1:0]  lane_x;
      logic [NUM_LANES-1:0][OPND_W-1:0]  lane_y;
      logic [NUM_GRP-1:0][OPND_W-1:0]    addend;
   } opnd_type;

   typedef struct packed {
      logic [OP_W-1:0]                   op;
      logic [NUM_LANES-1:0][PROD_W-1:0]  prod;
      logic [NUM_GRP-1:0][OPND_W-1:0]    addend;
   } prod_type;

   typedef struct packed {
      logic [OP_W-1:0]                op;
      logic [NUM_GRP-1:0][SUM_W-1:0]  sum;
   } sum_type;

   typedef struct packed {
      logic [3:0][IO_W-1:0]  r;
      logic [IO_W-1:0]       scalar;
      logic                  overflow;
   } result_type;

   // Clamp a wide sum to the word range; top bit flags clipping
   function automatic logic [IO_W:0] sat_word(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] c;
      logic                    clip;
      c    = v;
      clip = 1'b0;
      if (v > SAT_HI) begin
         c    = SAT_HI;
         clip = 1'b1;
      end else if (v < SAT_LO) begin
         c    = SAT_LO;
         clip = 1'b1;
      end
      return {clip, c[IO_W-1:0]};
   endfunction

endpackage

// ----- src/vaxt_csr.sv -----
// Matrix register file behind the APB-style configuration port.
`timescale 1ns / 1ps

module vaxt_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [vaxt_pkg::CSR_AW-1:0] paddr,
   input  logic [vaxt_pkg::CSR_DW-1:0] pwdata,
   output logic [vaxt_pkg::CSR_DW-1:0] prdata,
   output logic                        pready,
   output vaxt_pkg::matrix_type        matrix
);
   import vaxt_pkg::*;

   logic [NUM_REGS-1:0][CSR_DW-1:0] regs_ff;
   logic [IDX_W-1:0]                idx;

   assign idx    = paddr[CSR_AW-1:CSR_AW-IDX_W];
   assign pready = 1'b1;
   assign prdata = regs_ff[idx];

   // Write on the access beat
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= REG_RESET;
      end else if (psel && penable && pwrite) begin
         regs_ff[idx] <= pwdata;
      end
   end

   // Unpack the registers into matrix elements
   for (genvar r = 0; r < 4; r++) begin : g_row
      for (genvar c = 0; c < 4; c++) begin : g_col
         assign matrix[r][c] = regs_ff[2*r + c/2][IO_W*(c%2) +: IO_W];
      end
   end

endmodule

// ----- src/vaxt_opsel.sv -----
// Operand stage: routes components to the multiplier lanes and forms addends.
`timescale 1ns / 1ps

module vaxt_opsel (
   input  logic                    clock,
   input  logic                    reset,
   input  vaxt_pkg::stage_ctl_type ctl,
   input  vaxt_pkg::item_type      item,
   input  vaxt_pkg::matrix_type    matrix,
   output logic                    out_valid,
   output vaxt_pkg::opnd_type      opnd
);
   import vaxt_pkg::*;

   logic                     valid_ff;
   opnd_type                 opnd_ff;
   opnd_type                 opnd_in;
   logic signed [OPND_W-1:0] a_ext [4];
   logic signed [OPND_W-1:0] b_ext [3];
   logic signed [OPND_W-1:0] frac_ext;

   // Sign-extend the vector operands by one bit so sums and differences stay exact; zero-extend the fraction
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         a_ext[i] = OPND_W'($signed(item.a[i]));
      end
      for (int i = 0; i < 3; i++) begin
         b_ext[i] = OPND_W'($signed(item.b[i]));
      end
      frac_ext = $signed(OPND_W'(item.frac));
   end

   // Route operands per opcode; unused lanes multiply zero
   always_comb begin
      opnd_in    = '0;
      opnd_in.op = item.op;
      case (item.op)
         OP_ADD: begin
            for (int j = 0; j < 3; j++) begin
               opnd_in.addend[j] = a_ext[j] + b_ext[j];
            end
         end
         OP_SUB: begin
            for (int j = 0; j < 3; j++) begin
               opnd_in.addend[j] = a_ext[j] - b_ext[j];
            end
         end
         OP_DOT: begin
            for (int i = 0; i < 3; i++) begin
               opnd_in.lane_x[i] = a_ext[i];
               opnd_in.lane_y[i] = b_ext[i];
            end
         end
         OP_CROSS: begin
            // Each group takes first lane minus second lane
            opnd_in.lane_x[0] = a_ext[1];
            opnd_in.lane_y[0] = b_ext[2];
            opnd_in.lane_x[1] = a_ext[2];
            opnd_in.lane_y[1] = b_ext[1];
            opnd_in.lane_x[LANE_GRP]     = a_ext[2];
            opnd_in.lane_y[LANE_GRP]     = b_ext[0];
            opnd_in.lane_x[LANE_GRP + 1] = a_ext[0];
            opnd_in.lane_y[LANE_GRP + 1] = b_ext[2];
            opnd_in.lane_x[2*LANE_GRP]     = a_ext[0];
            opnd_in.lane_y[2*LANE_GRP]     = b_ext[1];
            opnd_in.lane_x[2*LANE_GRP + 1] = a_ext[1];
            opnd_in.lane_y[2*LANE_GRP + 1] = b_ext[0];
         end
         OP_LERP: begin
            for (int j = 0; j < 3; j++) begin
               opnd_in.lane_x[LANE_GRP*j] = b_ext[j] - a_ext[j];
               opnd_in.lane_y[LANE_GRP*j] = frac_ext;
               opnd_in.addend[j]          = a_ext[j];
            end
         end
         OP_XFORM: begin
            for (int j = 0; j < 4; j++) begin
               for (int i = 0; i < 4; i++) begin
                  opnd_in.lane_x[LANE_GRP*j + i] = a_ext[i];
                  opnd_in.lane_y[LANE_GRP*j + i] = OPND_W'($signed(matrix[i][j]));
               end
            end
         end
         default: begin
            opnd_in = '0;
            opnd_in.op = item.op;
         end
      endcase
   end

   // Advance the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.enable) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable && ctl.valid) begin
         opnd_ff <= opnd_in;
      end
   end

   assign out_valid = valid_ff;
   assign opnd      = opnd_ff;

endmodule

// ----- src/vaxt_mul.sv -----
// Multiplier stage: sixteen signed lanes, each product floored back to Q format.
`timescale 1ns / 1ps

module vaxt_mul (
   input  logic                    clock,
   input  logic                    reset,
   input  vaxt_pkg::stage_ctl_type ctl,
   input  vaxt_pkg::opnd_type      opnd,
   output logic                    out_valid,
   output vaxt_pkg::prod_type      prod
);
   import vaxt_pkg::*;

   logic                      valid_ff;
   prod_type                  prod_ff;
   prod_type                  prod_in;
   logic signed [PRODF_W-1:0] full [NUM_LANES];

   // Exact products, arithmetic shift rounds toward minus infinity
   always_comb begin
      prod_in        = '0;
      prod_in.op     = opnd.op;
      prod_in.addend = opnd.addend;
      for (int k = 0; k < NUM_LANES; k++) begin
         full[k] = $signed(opnd.lane_x[k]) * $signed(opnd.lane_y[k]);
         prod_in.prod[k] = PROD_W'(full[k] >>> FRAC_BITS);
      end
   end

   // Advance the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.enable) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable && ctl.valid) begin
         prod_ff <= prod_in;
      end
   end

   assign out_valid = valid_ff;
   assign prod      = prod_ff;

endmodule

// ----- src/vaxt_acc.sv -----
// Accumulate stage: adds each lane group and its addend at full width.
`timescale 1ns / 1ps

module vaxt_acc (
   input  logic                    clock,
   input  logic                    reset,
   input  vaxt_pkg::stage_ctl_type ctl,
   input  vaxt_pkg::prod_type      prod,
   output logic                    out_valid,
   output vaxt_pkg::sum_type       sum
);
   import vaxt_pkg::*;

   logic                    valid_ff;
   sum_type                 sum_ff;
   sum_type                 sum_in;
   logic                    neg_second;
   logic signed [SUM_W-1:0] term [NUM_GRP][LANE_GRP];

   // Cross product subtracts the second lane of each group
   assign neg_second = (prod.op == OP_CROSS);

   always_comb begin
      sum_in    = '0;
      sum_in.op = prod.op;
      for (int j = 0; j < NUM_GRP; j++) begin
         for (int i = 0; i < LANE_GRP; i++) begin
            term[j][i] = SUM_W'($signed(prod.prod[LANE_GRP*j + i]));
         end
         if (neg_second) begin
            term[j][1] = -term[j][1];
         end
         sum_in.sum[j] = SUM_W'($signed(prod.addend[j]))
                       + term[j][0] + term[j][1] + term[j][2] + term[j][3];
      end
   end

   // Advance the stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.enable) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable && ctl.valid) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = valid_ff;
   assign sum       = sum_ff;

endmodule

// ----- src/vaxt_sat.sv -----
// Output stage: saturates the group sums and assembles the result beat.
`timescale 1ns / 1ps

module vaxt_sat (
   input  logic                    clock,
   input  logic                    reset,
   input  vaxt_pkg::stage_ctl_type ctl,
   input  vaxt_pkg::sum_type       sum,
   output logic                    out_valid,
   output vaxt_pkg::result_type    result
);
   import vaxt_pkg::*;

   logic                     valid_ff;
   result_type               result_ff;
   result_type               result_in;
   logic [NUM_GRP-1:0][IO_W:0] clamp;

   always_comb begin
      for (int j = 0; j < NUM_GRP; j++) begin
         clamp[j] = sat_word($signed(sum.sum[j]));
      end
   end

   // Pick the result fields by opcode
   always_comb begin
      result_in = '0;
      case (sum.op)
         OP_ADD, OP_SUB, OP_CROSS, OP_LERP: begin
            for (int j = 0; j < 3; j++) begin
               result_in.r[j] = clamp[j][IO_W-1:0];
            end
            result_in.r[3]     = ONE_OUT;
            result_in.overflow = clamp[0][IO_W] | clamp[1][IO_W] | clamp[2][IO_W];
         end
         OP_DOT: begin
            result_in.scalar   = clamp[0][IO_W-1:0];
            result_in.overflow = clamp[0][IO_W];
         end
         OP_XFORM: begin
            for (int j = 0; j < NUM_GRP; j++) begin
               result_in.r[j] = clamp[j][IO_W-1:0];
            end
            result_in.overflow = clamp[0][IO_W] | clamp[1][IO_W]
                               | clamp[2][IO_W] | clamp[3][IO_W];
         end
         default: begin
            result_in = '0;
         end
      endcase
   end

   // Hold the result until the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.enable) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.enable && ctl.valid) begin
         result_ff <= result_in;
      end
   end

   assign out_valid = valid_ff;
   assign result    = result_ff;

endmodule

// ----- src/vector_alu_with_transform_core.sv -----
// Top level of the Q16.16 vector ALU with 4x4 matrix transform.
// Throughput: one beat per cycle while the response side is not stalled, through five
// register stages (input, operand select, multiply, accumulate, saturate); each stage
// fills when it is empty or its successor moves.
// Reset: synchronous, clears all stage valid bits and loads the identity matrix.
`timescale 1ns / 1ps

module vector_alu_with_transform_core (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [vaxt_pkg::OP_W-1:0]          req_opcode,
   input  logic signed [vaxt_pkg::IO_W-1:0]   req_a_x,
   input  logic signed [vaxt_pkg::IO_W-1:0]   req_a_y,
   input  logic signed [vaxt_pkg::IO_W-1:0]   req_a_z,
   input  logic signed [vaxt_pkg::IO_W-1:0]   req_a_w,
   input  logic signed [vaxt_pkg::IO_W-1:0]   req_b_x,
   input  logic signed [vaxt_pkg::IO_W-1:0]   req_b_y,
   input  logic signed [vaxt_pkg::IO_W-1:0]   req_b_z,
   input  logic [vaxt_pkg::FRAC_W-1:0]        req_frac,
   // Response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [vaxt_pkg::IO_W-1:0]   rsp_r_x,
   output logic signed [vaxt_pkg::IO_W-1:0]   rsp_r_y,
   output logic signed [vaxt_pkg::IO_W-1:0]   rsp_r_z,
   output logic signed [vaxt_pkg::IO_W-1:0]   rsp_r_w,
   output logic signed [vaxt_pkg::IO_W-1:0]   rsp_scalar,
   output logic                               rsp_overflow,
   // Configuration port
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [vaxt_pkg::CSR_AW-1:0]        paddr,
   input  logic [vaxt_pkg::CSR_DW-1:0]        pwdata,
   output logic [vaxt_pkg::CSR_DW-1:0]        prdata,
   output logic                               pready
);
   import vaxt_pkg::*;

   logic          in_valid_ff;
   item_type      item_ff;
   item_type      item_in;
   matrix_type    matrix;
   opnd_type      opnd;
   prod_type      prod;
   sum_type       sum;
   result_type    result;
   logic          opnd_valid, prod_valid, sum_valid, out_valid;
   logic          en_in, en_opnd, en_prod, en_sum, en_out;
   stage_ctl_type ctl_opnd, ctl_prod, ctl_sum, ctl_out;

   // Stage enables: a stage moves when it is empty or its successor moves
   assign en_out  = !out_valid  || !rsp_stall;
   assign en_sum  = !sum_valid  || en_out;
   assign en_prod = !prod_valid || en_sum;
   assign en_opnd = !opnd_valid || en_prod;
   assign en_in   = !in_valid_ff || en_opnd;

   assign req_stall = !en_in;

   assign ctl_opnd = '{valid: in_valid_ff, enable: en_opnd};
   assign ctl_prod = '{valid: opnd_valid,  enable: en_prod};
   assign ctl_sum  = '{valid: prod_valid,  enable: en_sum};
   assign ctl_out  = '{valid: sum_valid,   enable: en_out};

   // Capture the request beat
   always_comb begin
      item_in.op   = req_opcode;
      item_in.a[0] = req_a_x;
      item_in.a[1] = req_a_y;
      item_in.a[2] = req_a_z;
      item_in.a[3] = req_a_w;
      item_in.b[0] = req_b_x;
      item_in.b[1] = req_b_y;
      item_in.b[2] = req_b_z;
      item_in.frac = req_frac;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en_in) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_in && req_valid) begin
         item_ff <= item_in;
      end
   end

   vaxt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .matrix  (matrix)
   );

   vaxt_opsel u_opsel (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_opnd),
      .item      (item_ff),
      .matrix    (matrix),
      .out_valid (opnd_valid),
      .opnd      (opnd)
   );

   vaxt_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_prod),
      .opnd      (opnd),
      .out_valid (prod_valid),
      .prod      (prod)
   );

   vaxt_acc u_acc (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_sum),
      .prod      (prod),
      .out_valid (sum_valid),
      .sum       (sum)
   );

   vaxt_sat u_sat (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_out),
      .sum       (sum),
      .out_valid (out_valid),
      .result    (result)
   );

   // Drive the response beat
   assign rsp_valid    = out_valid;
   assign rsp_r_x      = result.r[0];
   assign rsp_r_y      = result.r[1];
   assign rsp_r_z      = result.r[2];
   assign rsp_r_w      = result.r[3];
   assign rsp_scalar   = result.scalar;
   assign rsp_overflow = result.overflow;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the Q16.16 vector ALU with 4x4 matrix transform.
`timescale 1ns / 1ps

module tb;
   import vaxt_pkg::*;

   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 206;
   localparam int PIPE_LATENCY    = 5;
   localparam int DRAIN_LIMIT     = 2000;
   localparam int HOLD_CYCLES     = 120;
   localparam int MAX_REPORTS     = 10;
   localparam int REG_STRIDE      = 8;
   localparam int IDLE_PCT        = 25;

   // Opcodes the block leaves undefined
   localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

   localparam logic [IO_W-1:0] W0   = 32'h0000_0000;
   localparam logic [IO_W-1:0] FX1  = 32'h0001_0000;
   localparam logic [IO_W-1:0] FX2  = 32'h0002_0000;
   localparam logic [IO_W-1:0] FX3  = 32'h0003_0000;
   localparam logic [IO_W-1:0] FX4  = 32'h0004_0000;
   localparam logic [IO_W-1:0] WMAX = 32'h7FFF_FFFF;
   localparam logic [IO_W-1:0] WMIN = 32'h8000_0000;
   localparam logic [IO_W-1:0] ALL1 = 32'hFFFF_FFFF;
   localparam longint WORD_HI = (longint'(1) <<< (WORD_WIDTH - 1)) - 1;
   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h1_0000;

   localparam logic [63:0] MAT_IDENTITY [NUM_REGS] = '{
      64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
      64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
   };

   typedef struct packed {
      logic [OP_W-1:0]         op;
      logic signed [IO_W-1:0]  a_x;
      logic signed [IO_W-1:0]  a_y;
      logic signed [IO_W-1:0]  a_z;
      logic signed [IO_W-1:0]  a_w;
      logic signed [IO_W-1:0]  b_x;
      logic signed [IO_W-1:0]  b_y;
      logic signed [IO_W-1:0]  b_z;
      logic [FRAC_W-1:0]       frac;
   } vec_req_type;

   typedef struct packed {
      logic signed [IO_W-1:0]  r_x;
      logic signed [IO_W-1:0]  r_y;
      logic signed [IO_W-1:0]  r_z;
      logic signed [IO_W-1:0]  r_w;
      logic signed [IO_W-1:0]  scalar;
      logic                    overflow;
   } vec_result_type;

   typedef struct packed {
      vec_req_type     req;
      logic            typed;
      vec_result_type  want;
   } dir_row_type;

   typedef enum int {
      MAT_RESET, MAT_SMALL, MAT_ALL_MAX, MAT_ALL_MIN, MAT_ZERO, MAT_FULL_RANDOM
   } mat_setting_type;

   localparam vec_result_type NO_WANT = '0;

   // Directed rows: typed expectation where it is obvious, predictor otherwise
   localparam int DIR_ROWS = 22;
   localparam dir_row_type DIRECTED [DIR_ROWS] = '{
      '{'{OP_ADD, W0, W0, W0, W0, W0, W0, W0, 17'h0}, 1'b1,
        '{W0, W0, W0, FX1, W0, 1'b0}},
      '{'{OP_ADD, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, WMAX, 17'h0}, 1'b1,
        '{WMAX, WMAX, WMAX, FX1, W0, 1'b1}},
      '{'{OP_ADD, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, WMIN, 17'h0}, 1'b1,
        '{WMIN, WMIN, WMIN, FX1, W0, 1'b1}},
      '{'{OP_SUB, WMIN, WMIN, WMIN, W0, WMAX, WMAX, WMAX, 17'h0}, 1'b1,
        '{WMIN, WMIN, WMIN, FX1, W0, 1'b1}},
      '{'{OP_SUB, WMAX, WMAX, WMAX, W0, WMIN, WMIN, WMIN, 17'h0}, 1'b1,
        '{WMAX, WMAX, WMAX, FX1, W0, 1'b1}},
      '{'{OP_SUB, ALL1, ALL1, ALL1, ALL1, W0, W0, W0, 17'h1_FFFF}, 1'b0, NO_WANT},
      '{'{OP_DOT, FX1, FX2, FX3, W0, FX4, 32'h0005_0000, 32'h0006_0000, 17'h0}, 1'b1,
        '{W0, W0, W0, W0, 32'h0020_0000, 1'b0}},
      '{'{OP_DOT, WMAX, WMAX, WMAX, W0, WMAX, WMAX, WMAX, 17'h0}, 1'b1,
        '{W0, W0, W0, W0, WMAX, 1'b1}},
      '{'{OP_DOT, WMIN, WMIN, WMIN, W0, WMIN, WMIN, WMIN, 17'h0}, 1'b1,
        '{W0, W0, W0, W0, WMAX, 1'b1}},
      '{'{OP_DOT, WMAX, WMAX, WMAX, W0, WMIN, WMIN, WMIN, 17'h0}, 1'b1,
        '{W0, W0, W0, W0, WMIN, 1'b1}},
      '{'{OP_CROSS, FX1, W0, W0, W0, W0, FX1, W0, 17'h0}, 1'b1,
        '{W0, W0, FX1, FX1, W0, 1'b0}},
      '{'{OP_CROSS, WMAX, WMIN, WMAX, W0, WMIN, WMAX, WMIN, 17'h0}, 1'b0, NO_WANT},
      '{'{OP_LERP, 32'h0005_0000, 32'hFFFD_0000, 32'h0007_8000, 32'h1234_5678,
          32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 17'h0}, 1'b1,
        '{32'h0005_0000, 32'hFFFD_0000, 32'h0007_8000, FX1, W0, 1'b0}},
      '{'{OP_LERP, 32'h0005_0000, 32'hFFFD_0000, 32'h0007_8000, W0,
          FX1, 32'h1234_5678, 32'hFFFF_8000, FRAC_ONE}, 1'b1,
        '{FX1, 32'h1234_5678, 32'hFFFF_8000, FX1, W0, 1'b0}},
      '{'{OP_LERP, WMIN, WMIN, WMIN, W0, WMAX, WMAX, WMAX, 17'h1_FFFF}, 1'b0, NO_WANT},
      '{'{OP_LERP, W0, W0, W0, W0, ALL1, ALL1, ALL1, 17'h0_8000}, 1'b0, NO_WANT},
      '{'{OP_LERP, WMAX, WMAX, WMAX, W0, WMIN, WMIN, WMIN, FRAC_ONE}, 1'b0, NO_WANT},
      '{'{OP_XFORM, FX1, FX2, FX3, FX4, W0, W0, W0, 17'h0}, 1'b1,
        '{FX1, FX2, FX3, FX4, W0, 1'b0}},
      '{'{OP_XFORM, WMIN, WMAX, WMIN, WMAX, W0, W0, W0, 17'h0}, 1'b0, NO_WANT},
      '{'{OP_UNDEF_LO, 32'h5A5A_5A5A, 32'hA5A5_A5A5, WMAX, WMIN,
          FX1, FX2, FX3, 17'h1_5A5A}, 1'b1, '{W0, W0, W0, W0, W0, 1'b0}},
      '{'{OP_UNDEF_HI, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, 17'h1_FFFF}, 1'b1,
        '{W0, W0, W0, W0, W0, 1'b0}},
      '{'{OP_CROSS, 32'h0001_8000, 32'hFFFE_4000, 32'h0000_0123,
          W0, 32'hFFFF_FFF0, 32'h0003_0001, 32'h8765_4321, 17'h0}, 1'b0, NO_WANT}
   };

   localparam mat_setting_type PHASE_PLAN [NUM_PHASES] = '{
      MAT_SMALL, MAT_ALL_MAX, MAT_ALL_MIN, MAT_ZERO,
      MAT_FULL_RANDOM, MAT_SMALL, MAT_FULL_RANDOM, MAT_RESET
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [OP_W-1:0]         req_opcode = '0;
   logic signed [IO_W-1:0]  req_a_x = '0;
   logic signed [IO_W-1:0]  req_a_y = '0;
   logic signed [IO_W-1:0]  req_a_z = '0;
   logic signed [IO_W-1:0]  req_a_w = '0;
   logic signed [IO_W-1:0]  req_b_x = '0;
   logic signed [IO_W-1:0]  req_b_y = '0;
   logic signed [IO_W-1:0]  req_b_z = '0;
   logic [FRAC_W-1:0]       req_frac = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [IO_W-1:0]  rsp_r_x;
   logic signed [IO_W-1:0]  rsp_r_y;
   logic signed [IO_W-1:0]  rsp_r_z;
   logic signed [IO_W-1:0]  rsp_r_w;
   logic signed [IO_W-1:0]  rsp_scalar;
   logic                    rsp_overflow;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [CSR_AW-1:0]       paddr = '0;
   logic [CSR_DW-1:0]       pwdata = '0;
   logic [CSR_DW-1:0]       prdata;
   logic                    pready;

   logic [63:0]     model_matrix [NUM_REGS] = MAT_IDENTITY;
   vec_result_type  pending_results [$];
   int              fail_cnt = 0;
   bit              tx_quiet = 1'b0;
   bit              rx_quiet = 1'b0;
   bit              rx_hold_req = 1'b0;

   vector_alu_with_transform_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_a_x      (req_a_x),
      .req_a_y      (req_a_y),
      .req_a_z      (req_a_z),
      .req_a_w      (req_a_w),
      .req_b_x      (req_b_x),
      .req_b_y      (req_b_y),
      .req_b_z      (req_b_z),
      .req_frac     (req_frac),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_r_x      (rsp_r_x),
      .rsp_r_y      (rsp_r_y),
      .rsp_r_z      (rsp_r_z),
      .rsp_r_w      (rsp_r_w),
      .rsp_scalar   (rsp_scalar),
      .rsp_overflow (rsp_overflow),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Exact product, shifted back with rounding toward minus infinity
   function automatic longint fixed_mul(longint x, longint y);
      return (x * y) >>> FRAC_BITS;
   endfunction

   // Clip to the word range; top bit reports clipping
   function automatic logic [IO_W:0] clip_word(longint v);
      longint lo;
      lo = -WORD_HI - 1;
      if (v > WORD_HI)
         return {1'b1, IO_W'(WORD_HI)};
      if (v < lo)
         return {1'b1, IO_W'(lo)};
      return {1'b0, IO_W'(v)};
   endfunction

   function automatic longint matrix_elem(int row, int col);
      logic [63:0]             word;
      logic signed [IO_W-1:0]  e;
      word = model_matrix[row * 2 + col / 2];
      e = (col % 2 == 1) ? word[63:32] : word[31:0];
      return e;
   endfunction

   function automatic vec_result_type compute_vec_result(vec_req_type q);
      longint           a [4];
      longint           b [3];
      longint           r [4];
      longint           s, f, one, acc;
      logic [IO_W:0]    c;
      logic [IO_W-1:0]  outw [5];
      logic             ovf;
      vec_result_type   res;
      a[0] = q.a_x; a[1] = q.a_y; a[2] = q.a_z; a[3] = q.a_w;
      b[0] = q.b_x; b[1] = q.b_y; b[2] = q.b_z;
      f = q.frac;
      r = '{default: 0};
      s = 0;
      ovf = 1'b0;
      one = longint'(1) <<< FRAC_BITS;
      if (one > WORD_HI)
         one = WORD_HI;
      case (q.op)
         OP_ADD: begin
            for (int i = 0; i < 3; i++) r[i] = a[i] + b[i];
            r[3] = one;
         end
         OP_SUB: begin
            for (int i = 0; i < 3; i++) r[i] = a[i] - b[i];
            r[3] = one;
         end
         OP_DOT: begin
            s = fixed_mul(a[0], b[0]) + fixed_mul(a[1], b[1]) + fixed_mul(a[2], b[2]);
         end
         OP_CROSS: begin
            r[0] = fixed_mul(a[1], b[2]) - fixed_mul(a[2], b[1]);
            r[1] = fixed_mul(a[2], b[0]) - fixed_mul(a[0], b[2]);
            r[2] = fixed_mul(a[0], b[1]) - fixed_mul(a[1], b[0]);
            r[3] = one;
         end
         OP_LERP: begin
            for (int i = 0; i < 3; i++) r[i] = a[i] + fixed_mul(b[i] - a[i], f);
            r[3] = one;
         end
         OP_XFORM: begin
            for (int j = 0; j < 4; j++) begin
               acc = 0;
               for (int i = 0; i < 4; i++) acc += fixed_mul(a[i], matrix_elem(i, j));
               r[j] = acc;
            end
         end
         default: ;
      endcase
      // Zero and the clipped one never trip the overflow flag, so clip all
      for (int k = 0; k < 5; k++) begin
         c = clip_word((k < 4) ? r[k] : s);
         outw[k] = c[IO_W-1:0];
         ovf |= c[IO_W];
      end
      res = '{outw[0], outw[1], outw[2], outw[3], outw[4], ovf};
      return res;
   endfunction

   function automatic logic [IO_W-1:0] rand_operand();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return IO_W'($urandom_range(32'h0010_0000) - 32'h0008_0000);
         5, 6, 7:       return IO_W'($urandom);
         default: begin
            case ($urandom_range(3))
               0:       return WMAX;
               1:       return WMIN;
               2:       return W0;
               default: return ALL1;
            endcase
         end
      endcase
   endfunction

   function automatic logic [FRAC_W-1:0] rand_frac();
      case ($urandom_range(7))
         0:       return '0;
         1:       return FRAC_ONE;
         2:       return FRAC_W'($urandom_range(17'h1_FFFF));
         default: return FRAC_W'($urandom_range(FRAC_ONE));
      endcase
   endfunction

   function automatic vec_req_type rand_req();
      vec_req_type q;
      if ($urandom_range(19) == 0)
         q.op = OP_W'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
      else
         q.op = OP_W'($urandom_range(OP_XFORM));
      q.a_x = rand_operand();
      q.a_y = rand_operand();
      q.a_z = rand_operand();
      q.a_w = rand_operand();
      q.b_x = rand_operand();
      q.b_y = rand_operand();
      q.b_z = rand_operand();
      q.frac = rand_frac();
      return q;
   endfunction

   function automatic logic [63:0] matrix_word(mat_setting_type setting, int idx);
      case (setting)
         MAT_RESET:   return MAT_IDENTITY[idx];
         MAT_SMALL:   return {IO_W'($urandom_range(32'h0008_0000) - 32'h0004_0000),
                              IO_W'($urandom_range(32'h0008_0000) - 32'h0004_0000)};
         MAT_ALL_MAX: return {WMAX, WMAX};
         MAT_ALL_MIN: return {WMIN, WMIN};
         MAT_ZERO:    return 64'h0;
         default:     return {$urandom, $urandom};
      endcase
   endfunction

   function automatic string fmt_result(vec_result_type v);
      return $sformatf("x=%h y=%h z=%h w=%h s=%h ovf=%b",
                       v.r_x, v.r_y, v.r_z, v.r_w, v.scalar, v.overflow);
   endfunction

   function automatic void log_failure(string msg);
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
         $display("%0t: %s", $time, msg);
   endfunction

   // Offer one beat after a random gap unless tx_quiet is set, hold it until taken, record the expectation
   task automatic send_req(vec_req_type q, logic typed, vec_result_type want);
      if (!tx_quiet) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid  <= 1'b1;
      req_opcode <= q.op;
      req_a_x    <= q.a_x;
      req_a_y    <= q.a_y;
      req_a_z    <= q.a_z;
      req_a_w    <= q.a_w;
      req_b_x    <= q.b_x;
      req_b_y    <= q.b_y;
      req_b_z    <= q.b_z;
      req_frac   <= q.frac;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(typed ? want : compute_vec_result(q));
   endtask

   // Drop valid, wait for every outstanding result, then let the pipe settle
   task automatic end_burst();
      int n;
      req_valid <= 1'b0;
      for (n = 0; pending_results.size() != 0 && n < DRAIN_LIMIT; n++)
         @(posedge clock);
      if (pending_results.size() != 0) begin
         log_failure($sformatf("%0d results never arrived", pending_results.size()));
         fail_cnt += pending_results.size() - 1;
         pending_results.delete();
      end
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic csr_write(int idx, logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'(idx * REG_STRIDE);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      model_matrix[idx] = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_matrix(mat_setting_type setting);
      for (int i = 0; i < NUM_REGS; i++)
         csr_write(i, matrix_word(setting, i));
   endtask

   // Result side: random stall, a quiet stretch, and one long hold-off
   initial begin : result_stall
      int hold_cnt;
      forever begin
         @(posedge clock);
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) begin
               rsp_stall <= 1'b1;
               @(posedge clock);
            end
         end
         rsp_stall <= rx_quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Compare each result beat with the oldest expectation
   always @(posedge clock) begin : result_check
      vec_result_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_r_x, rsp_r_y, rsp_r_z, rsp_r_w, rsp_scalar, rsp_overflow};
         if (pending_results.size() == 0) begin
            log_failure({"unexpected result beat: ", fmt_result(got)});
         end else begin
            want = pending_results.pop_front();
            if (got.r_x !== want.r_x || got.r_y !== want.r_y || got.r_z !== want.r_z ||
                got.r_w !== want.r_w || got.scalar !== want.scalar ||
                got.overflow !== want.overflow)
               log_failure({"result mismatch: expected ", fmt_result(want),
                            ", got ", fmt_result(got)});
         end
      end
   end

   initial begin : stimulus
      int ph, n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table against the reset matrix
      for (n = 0; n < DIR_ROWS; n++)
         send_req(DIRECTED[n].req, DIRECTED[n].typed, DIRECTED[n].want);
      end_burst();

      // Random beats under a different matrix each phase
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         load_matrix(PHASE_PLAN[ph]);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            tx_quiet = (ph == 3 && n < 150);
            rx_quiet = (ph == 3 && n < 150);
            if (ph == 0 && n == 40)
               rx_hold_req = 1'b1;
            send_req(rand_req(), 1'b0, NO_WANT);
         end
         tx_quiet = 1'b0;
         rx_quiet = 1'b0;
         end_burst();
      end

      if (fail_cnt == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/vaxt_pkg.sv
src/vaxt_csr.sv
src/vaxt_opsel.sv
src/vaxt_mul.sv
src/vaxt_acc.sv
src/vaxt_sat.sv
src/vector_alu_with_transform_core.sv
sim/tb.sv
